FILE: hdl/fstr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the fan speed regulator.
package fstr_pkg;

	localparam int TEMP_FRAC_BITS = 12;

	localparam int RAW_W     = 16;
	localparam int RAW_FRAC  = 7;
	localparam int TEMP_W    = RAW_W + TEMP_FRAC_BITS - RAW_FRAC;
	localparam int FILT_W    = 21;
	localparam int SPEED_W   = 16;
	localparam int INTV_W    = 8;
	localparam int GAIN_W    = 13;
	localparam int GAIN_BITS = 12;
	localparam int BYTE_W    = 8;
	localparam int DIFF_W    = ((TEMP_W > FILT_W) ? TEMP_W : FILT_W) + 1;
	localparam int PROD_W    = TEMP_W + GAIN_W;
	localparam int ACC_W     = PROD_W + 1;
	localparam int SUM_W     = SPEED_W + 2;
	localparam int STEP_W    = 7;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_BITS);
	localparam logic [ACC_W-1:0]  FILT_HALF = ACC_W'(1 << (GAIN_BITS - 1));

	localparam int BAND_I  = ((4 << TEMP_FRAC_BITS) + 50) / 100;
	localparam int BIG_I   = ((1 << TEMP_FRAC_BITS) + 50) / 100;
	localparam int SMALL_I = ((2 << TEMP_FRAC_BITS) + 500) / 1000;

	localparam logic signed [DIFF_W-1:0] ERR_BAND    = DIFF_W'(BAND_I);
	localparam logic signed [DIFF_W-1:0] TREND_BIG   = DIFF_W'(BIG_I);
	localparam logic signed [DIFF_W-1:0] TREND_SMALL = DIFF_W'(SMALL_I);

	localparam logic signed [STEP_W-1:0] STEP_NONE     = STEP_W'(0);
	localparam logic signed [STEP_W-1:0] STEP_IN_BIG   = STEP_W'(40);
	localparam logic signed [STEP_W-1:0] STEP_IN_SMALL = STEP_W'(20);
	localparam logic signed [STEP_W-1:0] STEP_OUT_BIG  = STEP_W'(50);
	localparam logic signed [STEP_W-1:0] STEP_OUT_BASE = STEP_W'(30);

	localparam int QUO_W  = 22;
	localparam int TACH_W = 13;
	localparam logic [QUO_W-1:0]  TACH_NUM = QUO_W'(3932160);
	localparam logic [TACH_W-1:0] TACH_MAX = '1;

	localparam int MOD_STEPS = INTV_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_POINT   = 3'd0,
		CFG_INTERVAL    = 3'd1,
		CFG_GAIN        = 3'd2,
		CFG_START_RPM   = 3'd3,
		CFG_RPM_FLOOR   = 3'd4,
		CFG_RPM_CEILING = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_MOD,
		S_TREND,
		S_STEP,
		S_ADD,
		S_CLAMP,
		S_DIV_LD,
		S_DIV,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_MUL_A,
		OP_MUL_B,
		OP_DIV_STEP,
		OP_TREND,
		OP_STEP,
		OP_ADD,
		OP_CLAMP,
		OP_DIV_LD,
		OP_LOAD_OUT
	} op_t;

endpackage

FILE: hdl/fstr_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples, results and register writes.
interface fstr_in_if;
	import fstr_pkg::*;
	logic              valid;
	logic              ready;
	logic [RAW_W-1:0]  raw_temperature;
	modport source (output valid, output raw_temperature, input ready);
	modport sink (input valid, input raw_temperature, output ready);
endinterface

interface fstr_out_if;
	import fstr_pkg::*;
	logic               valid;
	logic               ready;
	logic [FILT_W-1:0]  filtered_temp;
	logic [SPEED_W-1:0] target_speed;
	logic [BYTE_W-1:0]  tach_low_byte;
	logic [BYTE_W-1:0]  tach_high_byte;
	logic               adjusted;
	modport source (output valid, output filtered_temp, output target_speed,
		output tach_low_byte, output tach_high_byte, output adjusted, input ready);
	modport sink (input valid, input filtered_temp, input target_speed,
		input tach_low_byte, input tach_high_byte, input adjusted, output ready);
endinterface

interface fstr_cfg_if;
	import fstr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/fstr_seq.sv
`timescale 1ns / 1ps
// Sequencer that steps the shared datapath through one tick and holds the result slot.
module fstr_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output fstr_pkg::op_t     op
);
	import fstr_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             iterating;

	assign out_valid = out_valid_q;
	assign iterating = (state_q == S_MOD) || (state_q == S_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (iterating) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (op == OP_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_CAPTURE;
					state_d = S_MUL_A;
				end
			end
			S_MUL_A: begin
				op      = OP_MUL_A;
				state_d = S_MUL_B;
			end
			S_MUL_B: begin
				op      = OP_MUL_B;
				state_d = S_MOD;
			end
			S_MOD: begin
				op = OP_DIV_STEP;
				if (cnt_q == CNT_W'(MOD_STEPS - 1)) begin
					state_d = S_TREND;
				end
			end
			S_TREND: begin
				op      = OP_TREND;
				state_d = S_STEP;
			end
			S_STEP: begin
				op      = OP_STEP;
				state_d = S_ADD;
			end
			S_ADD: begin
				op      = OP_ADD;
				state_d = S_CLAMP;
			end
			S_CLAMP: begin
				op      = OP_CLAMP;
				state_d = S_DIV_LD;
			end
			S_DIV_LD: begin
				op      = OP_DIV_LD;
				state_d = S_DIV;
			end
			S_DIV: begin
				op = OP_DIV_STEP;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					op      = OP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/fstr_dp.sv
`timescale 1ns / 1ps
// Datapath with registers, shared multiplier and shared restoring divider.
module fstr_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fstr_pkg::op_t                   op,
	input  logic [fstr_pkg::RAW_W-1:0]      raw_temperature,
	input  logic                            cfg_write,
	input  logic [fstr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fstr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [fstr_pkg::FILT_W-1:0]     filtered_temp,
	output logic [fstr_pkg::SPEED_W-1:0]    target_speed,
	output logic [fstr_pkg::BYTE_W-1:0]     tach_low_byte,
	output logic [fstr_pkg::BYTE_W-1:0]     tach_high_byte,
	output logic                            adjusted
);
	import fstr_pkg::*;

	logic [FILT_W-1:0]  set_point_q;
	logic [INTV_W-1:0]  intv_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SPEED_W-1:0] floor_q;
	logic [SPEED_W-1:0] ceil_q;

	logic [TEMP_W-1:0]        f_q;
	logic [TEMP_W-1:0]        base_q;
	logic signed [DIFF_W-1:0] trend_q;
	logic [INTV_W-1:0]        c_q;
	logic [SPEED_W-1:0]       speed_q;

	logic [RAW_W-1:0]         raw_q;
	logic [ACC_W-1:0]         acc_q;
	logic [SPEED_W-1:0]       rem_q;
	logic [QUO_W-1:0]         quo_q;
	logic [SPEED_W-1:0]       dvs_q;
	logic signed [DIFF_W-1:0] err_q;
	logic                     adj_q;
	logic signed [STEP_W-1:0] step_q;
	logic signed [SUM_W-1:0]  sum_q;

	logic [GAIN_W-1:0]        g_eff;
	logic [INTV_W-1:0]        u_eff;
	logic [TEMP_W-1:0]        samp;
	logic [TEMP_W-1:0]        mul_a;
	logic [GAIN_W-1:0]        mul_b;
	logic [PROD_W-1:0]        prod;
	logic [ACC_W-1:0]         filt_sum;
	logic [TEMP_W-1:0]        f_next;
	logic [SPEED_W:0]         shifted;
	logic [SPEED_W+1:0]       diff;
	logic signed [DIFF_W-1:0] f_ext;
	logic signed [DIFF_W-1:0] base_ext;
	logic signed [DIFF_W-1:0] sp_ext;
	logic                     adj_now;
	logic                     in_band;
	logic signed [STEP_W-1:0] step_next;
	logic signed [SUM_W-1:0]  ceil_ext;
	logic signed [SUM_W-1:0]  floor_ext;
	logic signed [SUM_W-1:0]  clip_hi;
	logic signed [SUM_W-1:0]  clip_lo;
	logic [TACH_W-1:0]        tach;

	assign g_eff    = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
	assign u_eff    = (intv_q == '0) ? INTV_W'(1) : intv_q;
	assign samp     = TEMP_W'(raw_q) << (TEMP_FRAC_BITS - RAW_FRAC);
	assign mul_a    = (op == OP_MUL_A) ? f_q : samp;
	assign mul_b    = (op == OP_MUL_A) ? (GAIN_ONE - g_eff) : g_eff;
	assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign filt_sum = acc_q + ACC_W'(prod) + FILT_HALF;
	assign f_next   = TEMP_W'(filt_sum >> GAIN_BITS);

	assign shifted = {rem_q, quo_q[QUO_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	assign f_ext    = signed'(DIFF_W'(f_q));
	assign base_ext = signed'(DIFF_W'(base_q));
	assign sp_ext   = signed'(DIFF_W'(set_point_q));
	assign adj_now  = (c_q == '0) || (rem_q == '0);
	assign in_band  = (err_q <= ERR_BAND) && (err_q >= -ERR_BAND);

	always_comb begin
		priority if (in_band) begin
			priority if (trend_q >= TREND_BIG) begin
				step_next = STEP_IN_BIG;
			end else if (trend_q <= -TREND_BIG) begin
				step_next = -STEP_IN_BIG;
			end else if (trend_q >= TREND_SMALL) begin
				step_next = STEP_IN_SMALL;
			end else if (trend_q <= -TREND_SMALL) begin
				step_next = -STEP_IN_SMALL;
			end else begin
				step_next = STEP_NONE;
			end
		end else if (trend_q >= TREND_BIG) begin
			step_next = STEP_OUT_BIG;
		end else if (trend_q <= -TREND_BIG) begin
			step_next = -STEP_OUT_BIG;
		end else if (err_q > ERR_BAND) begin
			step_next = STEP_OUT_BASE;
		end else begin
			step_next = -STEP_OUT_BASE;
		end
	end

	assign ceil_ext  = signed'(SUM_W'(ceil_q));
	assign floor_ext = signed'(SUM_W'(floor_q));
	assign clip_hi   = (sum_q > ceil_ext) ? ceil_ext : sum_q;
	assign clip_lo   = (clip_hi < floor_ext) ? floor_ext : clip_hi;
	assign tach      = (quo_q[QUO_W-1:TACH_W] != '0) ? TACH_MAX : quo_q[TACH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_point_q <= FILT_W'(163840);
			intv_q      <= INTV_W'(10);
			gain_q      <= GAIN_W'(410);
			floor_q     <= SPEED_W'(481);
			ceil_q      <= SPEED_W'(16000);
			speed_q     <= SPEED_W'(4200);
			f_q         <= '0;
			base_q      <= '0;
			trend_q     <= '0;
			c_q         <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SET_POINT:   set_point_q <= cfg_data[FILT_W-1:0];
					CFG_INTERVAL:    intv_q      <= cfg_data[INTV_W-1:0];
					CFG_GAIN:        gain_q      <= cfg_data[GAIN_W-1:0];
					CFG_START_RPM:   speed_q     <= cfg_data[SPEED_W-1:0];
					CFG_RPM_FLOOR:   floor_q     <= cfg_data[SPEED_W-1:0];
					CFG_RPM_CEILING: ceil_q      <= cfg_data[SPEED_W-1:0];
					default: begin
					end
				endcase
			end
			case (op)
				OP_MUL_B: begin
					f_q <= f_next;
				end
				OP_TREND: begin
					if (c_q == '0 || c_q == INTV_W'(1)) begin
						base_q <= f_q;
					end else if (rem_q == '0) begin
						trend_q <= f_ext - base_ext;
					end
					c_q <= adj_now ? INTV_W'(1) : c_q + 1'b1;
				end
				OP_CLAMP: begin
					if (adj_q) begin
						speed_q <= clip_lo[SPEED_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_CAPTURE: begin
				raw_q <= raw_temperature;
			end
			OP_MUL_A: begin
				acc_q <= ACC_W'(prod);
				rem_q <= '0;
				quo_q <= {c_q, (QUO_W - INTV_W)'(0)};
				dvs_q <= SPEED_W'(u_eff);
			end
			OP_DIV_LD: begin
				rem_q <= '0;
				quo_q <= TACH_NUM;
				dvs_q <= speed_q;
			end
			OP_DIV_STEP: begin
				if (!diff[SPEED_W+1]) begin
					rem_q <= diff[SPEED_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[SPEED_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			OP_TREND: begin
				adj_q <= adj_now;
				err_q <= f_ext - sp_ext;
			end
			OP_STEP: begin
				step_q <= step_next;
			end
			OP_ADD: begin
				sum_q <= signed'(SUM_W'(speed_q)) + SUM_W'(step_q);
			end
			OP_LOAD_OUT: begin
				filtered_temp  <= FILT_W'(f_q);
				target_speed   <= speed_q;
				tach_low_byte  <= {tach[4:0], 3'b000};
				tach_high_byte <= tach[TACH_W-1:5];
				adjusted       <= adj_q;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/fan_speed_temperature_regulator_unit.sv
`timescale 1ns / 1ps
// Top level of the fan speed regulator: one temperature sample in, one speed result out.
//
// Usage:
//   sample: one raw sensor reading per transfer (LSB 1/128 degree).
//   result: filtered temperature, target speed, packed tach bytes and an adjust flag,
//           exactly one result per accepted sample, in order.
//   cfg:    register writes (index, data), always ready; write only while idle.
//           Writing the start speed also loads the current target speed.
// Processing:
//   sample.ready rises together with the result; a new sample is taken only after
//   the previous result has been loaded into the output register. Each sample runs
//   the 8-step tick-modulo pass and the 22-step restoring division for the tach
//   count, both on one shared subtractor, plus two passes of the shared filter
//   multiplier.
// Reset:
//   arst_n clears the filter, baseline, trend and tick counter, loads the register
//   defaults and the start speed, and empties the result slot.
// Stall:
//   A finished result waits in the output register; one more sample is taken and
//   processed meanwhile, and its result holds until the slot frees.
module fan_speed_temperature_regulator_unit (
	input  logic        clk,
	input  logic        arst_n,
	fstr_in_if.sink     sample,
	fstr_out_if.source  result,
	fstr_cfg_if.sink    cfg
);
	import fstr_pkg::*;

	op_t op;

	assign cfg.ready = 1'b1;

	fstr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.op        (op)
	);

	fstr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.raw_temperature (sample.raw_temperature),
		.cfg_write       (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.filtered_temp   (result.filtered_temp),
		.target_speed    (result.target_speed),
		.tach_low_byte   (result.tach_low_byte),
		.tach_high_byte  (result.tach_high_byte),
		.adjusted        (result.adjusted)
	);

endmodule

FILE: hdl/fstr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the fan speed regulator and its bind to the top level.
module fstr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [fstr_pkg::SPEED_W-1:0] out_target_speed,
	input logic [fstr_pkg::BYTE_W-1:0]  out_tach_low_byte
);
	import fstr_pkg::*;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while a tick is in progress");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_target_speed))
		else $error("stalled result dropped or changed");

	a_tach_low_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_tach_low_byte[2:0] == 3'b000)
		else $error("tach low register has unused bits set");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared right after a sample transfer");

endmodule

bind fan_speed_temperature_regulator_unit fstr_checker u_fstr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (sample.valid),
	.in_ready          (sample.ready),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.out_target_speed  (result.target_speed),
	.out_tach_low_byte (result.tach_low_byte)
);
